/* design/lapc_pkg.sv */
// ----------------------------------------------------------------------------
// lapc_pkg
// Shared types and constants for the layered box pair collision block:
// transaction payloads, controller-to-datapath command flags, count limits.
// ----------------------------------------------------------------------------
package lapc_pkg;

  localparam int FIELD_W   = 16;
  localparam int LAYER_W   = 3;
  localparam int IDX_OUT_W = 4;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0]   COUNT_MAX  = 5'd31;
  localparam logic [LAYER_W-1:0]   LAYER_NONE = 3'd0;

  typedef struct packed {
    logic                      box_enabled;
    logic [LAYER_W-1:0]        source_layer;
    logic [LAYER_W-1:0]        target_layer;
    logic signed [FIELD_W-1:0] centre_x;
    logic signed [FIELD_W-1:0] centre_y;
    logic [FIELD_W-1:0]        width;
    logic [FIELD_W-1:0]        height;
    logic                      last_box;
  } in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] box_index;
    logic [COUNT_W-1:0]   hit_count;
    logic                 overflowed;
    logic                 last_result;
  } out_t;

  // per-cycle command from the controller to the datapath
  typedef struct packed {
    logic load;       // write the incoming box into the store
    logic issue;      // a pair step is read from the store this cycle
    logic pair_ok;    // the pair is two distinct boxes
    logic row_first;  // first step for the current box
    logic row_last;   // last step for the current box, emit its count
    logic last_row;   // current box is the final loaded one
    logic ovf;        // boxes were dropped from this set
  } ctl_t;

endpackage

/* design/lapc_ctrl.sv */
// ----------------------------------------------------------------------------
// lapc_ctrl
// Load and scan controller: counts loaded boxes, tracks overflow, and walks
// every (box, other box) step of the pair scan, one step per cycle.
// ----------------------------------------------------------------------------
module lapc_ctrl #(
  parameter int MAX_BOXES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         last_box,
  output logic                         busy,
  output lapc_pkg::ctl_t               ctl,
  output logic [$clog2(MAX_BOXES)-1:0] wr_addr,
  output logic [$clog2(MAX_BOXES)-1:0] rd_a,
  output logic [$clog2(MAX_BOXES)-1:0] rd_b
);
  import lapc_pkg::*;

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [CW-1:0] n_m1;
  logic [IW-1:0] last_idx;

  assign n_m1     = n_r - CW'(1);
  assign last_idx = n_m1[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (n_r < CW'(MAX_BOXES)) begin
            ctl.load = 1'b1;
            n_nxt    = n_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (last_box) begin
            state_nxt = ST_RUN;
            i_nxt     = '0;
            j_nxt     = '0;
          end
        end
      end
      ST_RUN: begin
        ctl.issue     = 1'b1;
        ctl.pair_ok   = (i_r != j_r);
        ctl.row_first = (j_r == '0);
        ctl.row_last  = (j_r == last_idx);
        ctl.last_row  = (i_r == last_idx);
        ctl.ovf       = ovf_r;
        if (j_r == last_idx) begin
          j_nxt = '0;
          if (i_r == last_idx) begin
            // set finished, clear for the next load
            state_nxt = ST_IDLE;
            i_nxt     = '0;
            n_nxt     = '0;
            ovf_nxt   = 1'b0;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  assign busy    = (state_r != ST_IDLE);
  assign wr_addr = n_r[IW-1:0];
  assign rd_a    = i_r;
  assign rd_b    = j_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_BOXES))
    else $error("loaded box count above capacity");

  a_scan_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (n_r != '0) && (i_r <= last_idx) && (j_r <= last_idx))
    else $error("pair scan outside the loaded set");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && ctl.row_last && ctl.last_row) |=> (!busy && (n_r == '0) && !ovf_r))
    else $error("scan did not finish and clear the set");

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start && last_box) |=> (busy && (i_r == '0) && (j_r == '0)))
    else $error("last box did not start the scan at the first pair");
`endif

endmodule

/* design/lapc_datapath.sv */
// ----------------------------------------------------------------------------
// lapc_datapath
// Box store with one write and two registered read ports, the pair overlap
// and layer test, and the per-box hit count accumulator and result register.
// ----------------------------------------------------------------------------
module lapc_datapath #(
  parameter int MAX_BOXES   = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lapc_pkg::in_t                in_data,
  input  lapc_pkg::ctl_t               ctl,
  input  logic [$clog2(MAX_BOXES)-1:0] wr_addr,
  input  logic [$clog2(MAX_BOXES)-1:0] rd_a,
  input  logic [$clog2(MAX_BOXES)-1:0] rd_b,
  output logic                         out_strobe,
  output lapc_pkg::out_t               out_data
);
  import lapc_pkg::*;

  localparam int IW    = $clog2(MAX_BOXES);
  localparam int EW    = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 2;
  localparam int ENT_W = 1 + 2 * LAYER_W + 4 * EW;
  localparam int AW    = $clog2(2 * MAX_BOXES);
  localparam int SW    = (AW > COUNT_W) ? AW : COUNT_W;

  // edges are worked out once at load: left = c - floor(s/2), right = c + ceil(s/2)
  logic signed [COORD_WIDTH-1:0] cx, cy;
  logic signed [EW-1:0]          w_lx, w_rx, w_ly, w_ry;
  logic                          w_en;
  logic [ENT_W-1:0]              wr_ent;

  assign cx   = COORD_WIDTH'(in_data.centre_x);
  assign cy   = COORD_WIDTH'(in_data.centre_y);
  assign w_lx = EW'(cx) - EW'(in_data.width[FIELD_W-1:1]);
  assign w_rx = EW'(cx) + EW'(in_data.width[FIELD_W-1:1]) + EW'(in_data.width[0]);
  assign w_ly = EW'(cy) - EW'(in_data.height[FIELD_W-1:1]);
  assign w_ry = EW'(cy) + EW'(in_data.height[FIELD_W-1:1]) + EW'(in_data.height[0]);
  // an empty box never overlaps, so it is stored as disabled
  assign w_en = in_data.box_enabled & (|in_data.width) & (|in_data.height);
  assign wr_ent = {w_en, in_data.source_layer, in_data.target_layer,
                   w_lx, w_rx, w_ly, w_ry};

  logic [ENT_W-1:0] box_mem [MAX_BOXES];
  logic [ENT_W-1:0] ent_a_r, ent_b_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      box_mem[wr_addr] <= wr_ent;
    end
    ent_a_r <= box_mem[rd_a];
    ent_b_r <= box_mem[rd_b];
  end

  logic                 a_en, b_en;
  logic [LAYER_W-1:0]   a_src, a_dst, b_src, b_dst;
  logic signed [EW-1:0] a_lx, a_rx, a_ly, a_ry;
  logic signed [EW-1:0] b_lx, b_rx, b_ly, b_ry;

  assign {a_en, a_src, a_dst, a_lx, a_rx, a_ly, a_ry} = ent_a_r;
  assign {b_en, b_src, b_dst, b_lx, b_rx, b_ly, b_ry} = ent_b_r;

  ctl_t       p_r;
  logic       overlap_c, a_hits_b, b_hits_a, touch_c;
  logic [1:0] inc_c;

  assign overlap_c = (a_lx < b_rx) && (b_lx < a_rx) && (a_ly < b_ry) && (b_ly < a_ry);
  assign a_hits_b  = (a_dst != LAYER_NONE) && (a_dst == b_src);
  assign b_hits_a  = (b_dst != LAYER_NONE) && (b_dst == a_src);
  assign touch_c   = a_en && b_en && overlap_c && p_r.pair_ok;
  // the box is counted once as hitter and once as hurt side of each pair, each only where that layer test matches
  assign inc_c     = touch_c ? (2'(a_hits_b) + 2'(b_hits_a)) : 2'd0;

  logic [IW-1:0] idx_r;
  logic [AW-1:0] acc_r;
  logic [AW-1:0] sum_c;
  logic [SW-1:0] sum_w;
  logic [COUNT_W-1:0] hit_c;
  logic          out_valid_r;
  out_t          out_data_r;

  assign sum_c = (p_r.row_first ? '0 : acc_r) + AW'(inc_c);
  assign sum_w = SW'(sum_c);
  assign hit_c = (sum_w > SW'(COUNT_MAX)) ? COUNT_MAX : sum_w[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p_r         <= ctl;
      out_valid_r <= p_r.issue && p_r.row_last;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= rd_a;
    if (p_r.issue) begin
      acc_r <= sum_c;
    end
    if (p_r.issue && p_r.row_last) begin
      out_data_r.box_index   <= IDX_OUT_W'(idx_r);
      out_data_r.hit_count   <= hit_c;
      out_data_r.overflowed  <= p_r.ovf;
      out_data_r.last_result <= p_r.last_row;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

`ifndef SYNTH
  a_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (p_r.issue && !p_r.pair_ok) |-> (inc_c == 2'd0))
    else $error("a box was counted against itself");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(p_r.issue && p_r.row_last))
    else $error("result strobe without a finished box scan");

  a_last_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_result) |=> !out_strobe)
    else $error("result strobe right after the final result");
`endif

endmodule

/* design/layered_aabb_pair_collision.sv */
// ----------------------------------------------------------------------------
// layered_aabb_pair_collision
// All-pairs layered box overlap counter: loads a set of boxes, then reports
// per box how many counting overlaps it took part in.
// ----------------------------------------------------------------------------
// Each box is taken when start is high while busy is low. The item
// marked last_box raises busy for the whole pair scan of the n boxes
// held: the single pair comparator reads two boxes per cycle from the
// two-port box store and walks every (box, other box) step. Results come one
// per box, in load order, each on out_data for one cycle with out_strobe
// high; the last one appears in the cycle after busy falls. There is no
// back-pressure on the result side, so the receiver must take every strobe.
// Boxes beyond MAX_BOXES are dropped and flagged on every result of the set.
module layered_aabb_pair_collision #(
  parameter int MAX_BOXES   = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lapc_pkg::in_t  in_data,
  output logic           out_strobe,
  output lapc_pkg::out_t out_data
);
  import lapc_pkg::*;

  localparam int IW = $clog2(MAX_BOXES);

  ctl_t          ctl;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_a;
  logic [IW-1:0] rd_b;

  lapc_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_box (in_data.last_box),
    .busy     (busy),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  lapc_datapath #(
    .MAX_BOXES   (MAX_BOXES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .wr_addr    (wr_addr),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
